// File: rtl/dmtlb_pkg.sv
// shared types and constants for the direct-mapped tlb
package dmtlb_pkg;

  // payload field widths
  localparam int VPN_W = 20;
  localparam int PFN_W = 20;
  localparam int CNT_W = 32;

  // default configuration
  localparam int DEF_ENTRIES        = 64;
  localparam int DEF_PAGE_NUM_BITS  = 20;
  localparam int DEF_FRAME_NUM_BITS = 20;

  // action codes
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // request payload
  typedef struct packed {
    action_t            action;
    logic [VPN_W-1:0]   virt_page;
    logic [PFN_W-1:0]   phys_frame;
  } tlb_req_t;

  // response payload
  typedef struct packed {
    logic               hit;
    logic [PFN_W-1:0]   frame_out;
    logic [CNT_W-1:0]   lookups_done;
    logic [CNT_W-1:0]   hits_seen;
    logic [CNT_W-1:0]   misses_seen;
  } tlb_rsp_t;

  // event into the statistics counters
  typedef struct packed {
    logic lookup;
    logic hit;
    logic clear;
  } stat_ev_t;

  // counter values after the current transfer
  typedef struct packed {
    logic [CNT_W-1:0] lookups;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } stat_cnt_t;

endpackage

// File: rtl/dmtlb_ram.sv
// entry memory: one write port, one registered read port
module dmtlb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dmtlb_stats.sv
// lookup, hit and miss counters with clear
module dmtlb_stats
  import dmtlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  stat_ev_t  ev,
  output stat_cnt_t cnt
);

  logic [CNT_W-1:0] lookups;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] misses;

  // values after the event, reported with the same transfer
  always_comb begin
    cnt.lookups = lookups;
    cnt.hits    = hits;
    cnt.misses  = misses;
    if (ev.clear) begin
      cnt.lookups = '0;
      cnt.hits    = '0;
      cnt.misses  = '0;
    end else if (ev.lookup) begin
      cnt.lookups = lookups + CNT_W'(1);
      if (ev.hit) begin
        cnt.hits = hits + CNT_W'(1);
      end else begin
        cnt.misses = misses + CNT_W'(1);
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lookups <= '0;
      hits    <= '0;
      misses  <= '0;
    end else if (en) begin
      lookups <= cnt.lookups;
      hits    <= cnt.hits;
      misses  <= cnt.misses;
    end
  end

endmodule

// File: rtl/direct_mapped_tlb.sv
// direct-mapped tlb top level: index stage, entry memory, resolve stage, output register
//
// Each request is a lookup, insert, tag-matched invalidate or clear-all. Requests are
// taken one per cycle while in_ready is high: the first stage registers the request
// and the quotient of the page number by ENTRIES, the second forms the slot index and
// reads the entry memory, and the third compares the tag, writes the entry back and
// loads the response register, which offers the response. A write to the slot that
// the following request reads is forwarded. The response register lets a new request
// in while a response waits. After reset, and after a clear-all has left the
// pipeline, the block sweeps every slot of the entry memory, one slot a cycle, and
// holds in_ready low meanwhile; a clear-all also holds off later requests until it
// has passed the resolve stage.
module direct_mapped_tlb
  import dmtlb_pkg::*;
#(
  parameter int ENTRIES        = DEF_ENTRIES,
  parameter int PAGE_NUM_BITS  = DEF_PAGE_NUM_BITS,
  parameter int FRAME_NUM_BITS = DEF_FRAME_NUM_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tlb_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tlb_rsp_t out_data
);

  localparam int PW    = (PAGE_NUM_BITS < VPN_W) ? PAGE_NUM_BITS : VPN_W;
  localparam int FW    = (FRAME_NUM_BITS < PFN_W) ? FRAME_NUM_BITS : PFN_W;
  localparam int IW    = $clog2(ENTRIES);
  localparam int EW    = 1 + PW + FW;
  localparam int SHIFT = PW + IW;
  localparam int RW    = SHIFT + 1;
  localparam int QW    = PW + IW + 1;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'(ENTRIES));

  // ---------------- index stage ----------------
  logic          p_valid;
  action_t       p_action;
  logic [PW-1:0] p_page;
  logic [FW-1:0] p_frame;
  logic [PW-1:0] p_quot;

  logic [PW+RW-1:0] recip_prod;
  logic [PW-1:0]    in_page;
  logic [QW-1:0]    quot_mul;
  logic [QW-1:0]    rem_diff;
  logic [IW:0]      rem_raw;
  logic [IW-1:0]    p_idx;

  // ---------------- resolve stage ----------------
  logic          b_valid;
  action_t       b_action;
  logic [PW-1:0] b_page;
  logic [FW-1:0] b_frame;
  logic [IW-1:0] b_idx;
  logic          b_fwd;
  logic [EW-1:0] fwd_word;

  logic [EW-1:0] rd_word;
  logic [EW-1:0] entry;
  logic          entry_valid;
  logic [PW-1:0] entry_tag;
  logic [FW-1:0] entry_frame;
  logic          match;
  logic          b_we;
  logic [EW-1:0] b_wdata;

  // ---------------- sweep and memory port ----------------
  logic          sweep_busy;
  logic [IW-1:0] sweep_idx;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic      p_adv;
  logic      b_adv;
  logic      in_xfer;
  stat_ev_t  st_ev;
  stat_cnt_t st_cnt;

  // pipeline flow control
  assign b_adv   = b_valid && (!out_valid || out_ready);
  assign p_adv   = p_valid && (!b_valid || b_adv);
  assign in_ready = !sweep_busy
                 && !(p_valid && (p_action == ACT_CLEAR))
                 && !(b_valid && (b_action == ACT_CLEAR))
                 && (!p_valid || p_adv);
  assign in_xfer = in_valid && in_ready;

  // quotient of the page number by the entry count via reciprocal
  assign in_page    = in_data.virt_page[PW-1:0];
  assign recip_prod = (PW+RW)'(in_page) * (PW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_xfer) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_action <= in_data.action;
      p_page   <= in_page;
      p_frame  <= in_data.phys_frame[FW-1:0];
      p_quot   <= recip_prod[SHIFT +: PW];
    end
  end

  // remainder with one correction step
  assign quot_mul = QW'(p_quot) * QW'(ENTRIES);
  assign rem_diff = QW'(p_page) - quot_mul;
  assign rem_raw  = rem_diff[IW:0];
  assign p_idx    = (rem_raw >= (IW+1)'(ENTRIES)) ? IW'(rem_raw - (IW+1)'(ENTRIES))
                                                  : IW'(rem_raw);

  // resolve stage registers, with forwarding of a same-slot write
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (p_adv) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      b_action <= p_action;
      b_page   <= p_page;
      b_frame  <= p_frame;
      b_idx    <= p_idx;
      b_fwd    <= b_we && (b_idx == p_idx);
      fwd_word <= b_wdata;
    end
  end

  // entry compare and write-back value
  assign entry       = b_fwd ? fwd_word : rd_word;
  assign entry_valid = entry[EW-1];
  assign entry_tag   = entry[FW +: PW];
  assign entry_frame = entry[FW-1:0];
  assign match       = entry_valid && (entry_tag == b_page);

  always_comb begin
    b_we    = 1'b0;
    b_wdata = '0;
    unique case (b_action)
      ACT_LOOKUP: b_we = 1'b0;
      ACT_INSERT: begin
        b_we    = b_adv;
        b_wdata = {1'b1, b_page, b_frame};
      end
      ACT_INVAL:  b_we = b_adv && match;
      ACT_CLEAR:  b_we = 1'b0;
      default:    b_we = 1'b0;
    endcase
  end

  // clearing sweep after reset and after clear-all
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_busy <= 1'b1;
      sweep_idx  <= '0;
    end else if (sweep_busy) begin
      if (sweep_idx == IW'(ENTRIES - 1)) begin
        sweep_busy <= 1'b0;
      end
      sweep_idx <= sweep_idx + IW'(1);
    end else if (b_adv && (b_action == ACT_CLEAR)) begin
      sweep_busy <= 1'b1;
      sweep_idx  <= '0;
    end
  end

  // memory write port: sweep or resolve stage, never both
  assign mem_we    = sweep_busy || b_we;
  assign mem_waddr = sweep_busy ? sweep_idx : b_idx;
  assign mem_wdata = sweep_busy ? '0 : b_wdata;

  dmtlb_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (p_adv),
    .raddr (p_idx),
    .rdata (rd_word)
  );

  // statistics
  assign st_ev.lookup = (b_action == ACT_LOOKUP);
  assign st_ev.hit    = match;
  assign st_ev.clear  = (b_action == ACT_CLEAR);

  dmtlb_stats u_stats (
    .clk (clk),
    .rst (rst),
    .en  (b_adv),
    .ev  (st_ev),
    .cnt (st_cnt)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data.hit          <= ((b_action == ACT_LOOKUP) || (b_action == ACT_INVAL)) && match;
      out_data.frame_out    <= ((b_action == ACT_LOOKUP) && match) ? PFN_W'(entry_frame)
                                                                   : '0;
      out_data.lookups_done <= st_cnt.lookups;
      out_data.hits_seen    <= st_cnt.hits;
      out_data.misses_seen  <= st_cnt.misses;
    end
  end

`ifndef NO_ASSERTIONS
  // counters stay consistent: every lookup is a hit or a miss
  a_cnt_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(out_data.hits_seen + out_data.misses_seen) == out_data.lookups_done))
    else $error("hit and miss counts do not add up to lookups");

  // a clear-all leaving the resolve stage reports zeroed counters
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (b_adv && (b_action == ACT_CLEAR)) |=>
      (out_data.lookups_done == '0) && (out_data.hits_seen == '0)
      && (out_data.misses_seen == '0) && !out_data.hit)
    else $error("clear-all response carries nonzero counters");

  // the sweep never runs while requests are in the pipeline
  a_sweep_empty: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> (!p_valid && !b_valid))
    else $error("entry sweep overlaps a request in flight");
`endif

endmodule
